// File: hw/rtl/cas_pkg.sv
// Shared types and constants for the cartridge address sequencer.
// Used by cas_rem_unit and cart_address_sequencer_core; no dependencies.
package cas_pkg;

    localparam int ROM_ADDR_BITS = 20;
    localparam int COUNTER_W     = 32;
    localparam int SIZE_W        = 21;
    localparam int SHIFT_LEN_W   = 6;
    localparam int OUT_ADDR_W    = 20;
    localparam int BYTE_W        = 8;
    localparam int STEP_W        = $clog2(COUNTER_W);
    localparam int CFG_INDEX_W   = 3;

    localparam logic [COUNTER_W-1:0] ROM_ADDR_MASK =
        (ROM_ADDR_BITS >= COUNTER_W) ? {COUNTER_W{1'b1}}
                                     : ((COUNTER_W'(1) << ROM_ADDR_BITS) - COUNTER_W'(1));

    localparam logic [SHIFT_LEN_W-1:0] SHIFT_LEN_RESET = SHIFT_LEN_W'(8);

    // Access kinds carried on s_tuser
    typedef enum logic [3:0] {
        MODE_READ      = 4'd0,
        MODE_PEEK      = 4'd1,
        MODE_WRITE     = 4'd2,
        MODE_SET_LOW   = 4'd3,
        MODE_SET_HIGH  = 4'd4,
        MODE_SHIFT_BIT = 4'd5,
        MODE_BANK0_PG  = 4'd6,
        MODE_BANK1_PG  = 4'd7,
        MODE_SEL_BANK  = 4'd8
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BANK0_SIZE   = 3'd0,
        CFG_BANK1_OFFSET = 3'd1,
        CFG_BANK1_SIZE   = 3'd2,
        CFG_ROM_SIZE     = 3'd3,
        CFG_SHIFT_LENGTH = 3'd4,
        CFG_SAVE_RAM     = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REM,
        ST_DONE
    } state_t;

    // Status of the serial remainder unit
    typedef struct packed {
        logic busy;
        logic last;
    } rem_stat_t;

endpackage

// File: hw/rtl/cas_rem_unit.sv
// Bit-serial restoring remainder: counter modulo bank size, one bit per cycle.
// Depends on cas_pkg.
module cas_rem_unit
    import cas_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [COUNTER_W-1:0] dividend,
    input  logic [SIZE_W-1:0]    divisor,
    output rem_stat_t            stat,
    output logic [SIZE_W-1:0]    remainder
);

    logic                 busy_reg, busy_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [COUNTER_W-1:0] quot_reg, quot_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W-1:0]    div_reg, div_next;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;
    logic                 fits;

    // Bring down the next dividend bit and subtract when it fits
    assign trial = {rem_reg, quot_reg[COUNTER_W-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(COUNTER_W - 1);
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[COUNTER_W-2:0], 1'b0};
            rem_next  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.last = busy_reg && (step_reg == '0);
    assign remainder = rem_reg;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (div_reg != '0) |-> rem_reg < div_reg)
        else $error("partial remainder not below divisor");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.last && !start |=> !busy_reg)
        else $error("remainder unit did not stop after last step");
`endif

endmodule

// File: hw/rtl/cart_address_sequencer_core.sv
// Top level of the cartridge address sequencer: access decode, counter state,
// config registers and result register. Depends on cas_pkg and cas_rem_unit.
//
// One beat in gives one beat out. A read or peek with a nonzero size for the
// selected bank reduces the counter modulo that size in cas_rem_unit, one bit
// per cycle, so such an access holds the block through accept, 32 remainder
// steps and result before it takes another beat; all other accesses go from
// accept straight to result. The result sits in an output register, so the
// next beat is accepted while it waits on m_tready. Config writes are taken
// on any cycle (cfg_ready is tied high) and belong between accesses.
module cart_address_sequencer_core
    import cas_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data,
    // access channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,  // [7:0] data_byte, [8] serial_bit
    input  logic [3:0]             s_tuser,  // [3:0] mode
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [55:0]            m_tdata,  // [19:0] rom_address, [20] rom_in_range,
                                             // [40:21] save_address, [48:41] save_data
    output logic [1:0]             m_tuser   // [0] rom_valid, [1] save_write
);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]      bank0_size_reg, bank1_offset_reg, bank1_size_reg;
    logic [SIZE_W-1:0]      rom_size_reg, save_ram_reg;
    logic [SHIFT_LEN_W-1:0] shift_len_reg;

    logic [COUNTER_W-1:0]   counter_reg, counter_next;
    logic                   bank_reg, bank_next;
    logic [COUNTER_W-1:0]   acc_reg, acc_next;
    logic [SHIFT_LEN_W-1:0] scount_reg, scount_next;

    logic [3:0]             mode_reg;
    logic [BYTE_W-1:0]      data_reg;
    logic                   bit_reg;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [55:0]            m_tdata_reg, m_tdata_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;

    logic                   accept;
    logic                   rem_start;
    logic                   load_out;
    logic                   out_free;
    logic                   is_rom_access;
    logic [SIZE_W-1:0]      cur_size;
    logic [SIZE_W-1:0]      cur_offset;
    rem_stat_t              rem_stat;
    logic [SIZE_W-1:0]      rem_value;

    logic [COUNTER_W-1:0]   in_bank;
    logic [COUNTER_W-1:0]   rom_addr_full;
    logic [COUNTER_W-1:0]   rom_addr_kept;
    logic [SHIFT_LEN_W-1:0] scount_inc;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cur_size   = bank_reg ? bank1_size_reg : bank0_size_reg;
    assign cur_offset = bank_reg ? bank1_offset_reg : '0;
    assign is_rom_access = (mode_t'(s_tuser) == MODE_READ) || (mode_t'(s_tuser) == MODE_PEEK);

    cas_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (counter_reg),
        .divisor   (cur_size),
        .stat      (rem_stat),
        .remainder (rem_value)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (is_rom_access && cur_size != '0) ? ST_REM : ST_DONE;
                end
            end
            ST_REM: begin
                if (rem_stat.last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        rem_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                rem_start = accept && is_rom_access && (cur_size != '0);
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    // access datapath
    assign in_bank       = (cur_size != '0) ? COUNTER_W'(rem_value) : counter_reg;
    assign rom_addr_full = COUNTER_W'(cur_offset) + in_bank;
    assign rom_addr_kept = rom_addr_full & ROM_ADDR_MASK;
    assign scount_inc    = scount_reg + SHIFT_LEN_W'(1);

    always_comb begin
        counter_next  = counter_reg;
        bank_next     = bank_reg;
        acc_next      = acc_reg;
        scount_next   = scount_reg;
        m_tdata_next  = '0;
        m_tuser_next  = '0;
        case (mode_t'(mode_reg))
            MODE_READ, MODE_PEEK: begin
                m_tuser_next[0]    = 1'b1;
                m_tdata_next[19:0] = rom_addr_kept[OUT_ADDR_W-1:0];
                m_tdata_next[20]   = rom_addr_full < COUNTER_W'(rom_size_reg);
                if (mode_t'(mode_reg) == MODE_READ) begin
                    counter_next = counter_reg + COUNTER_W'(1);
                end
            end
            MODE_WRITE: begin
                if ((save_ram_reg != '0) && (counter_reg < COUNTER_W'(save_ram_reg))) begin
                    m_tuser_next[1]     = 1'b1;
                    m_tdata_next[40:21] = counter_reg[OUT_ADDR_W-1:0];
                    m_tdata_next[48:41] = data_reg;
                end
                counter_next = counter_reg + COUNTER_W'(1);
            end
            MODE_SET_LOW: begin
                counter_next = {16'd0, counter_reg[15:8], data_reg};
            end
            MODE_SET_HIGH: begin
                counter_next = {16'd0, data_reg, counter_reg[7:0]};
            end
            MODE_SHIFT_BIT: begin
                acc_next    = {acc_reg[COUNTER_W-2:0], bit_reg};
                scount_next = scount_inc;
                // load the counter once enough bits are in
                if (scount_inc >= shift_len_reg) begin
                    counter_next = {acc_reg[COUNTER_W-2:0], bit_reg};
                    acc_next     = '0;
                    scount_next  = '0;
                end
            end
            MODE_BANK0_PG, MODE_BANK1_PG: begin
                bank_next    = (mode_t'(mode_reg) == MODE_BANK1_PG);
                counter_next = {16'd0, data_reg, counter_reg[7:0]};
            end
            MODE_SEL_BANK: begin
                bank_next = (data_reg != '0);
            end
            default: ;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            bank0_size_reg   <= '0;
            bank1_offset_reg <= '0;
            bank1_size_reg   <= '0;
            rom_size_reg     <= '0;
            shift_len_reg    <= SHIFT_LEN_RESET;
            save_ram_reg     <= '0;
            counter_reg      <= '0;
            bank_reg         <= 1'b0;
            acc_reg          <= '0;
            scount_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_BANK0_SIZE:   bank0_size_reg   <= cfg_data;
                    CFG_BANK1_OFFSET: bank1_offset_reg <= cfg_data;
                    CFG_BANK1_SIZE:   bank1_size_reg   <= cfg_data;
                    CFG_ROM_SIZE:     rom_size_reg     <= cfg_data;
                    CFG_SHIFT_LENGTH: shift_len_reg    <= cfg_data[SHIFT_LEN_W-1:0];
                    CFG_SAVE_RAM:     save_ram_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (load_out) begin
                counter_reg <= counter_next;
                bank_reg    <= bank_next;
                acc_reg     <= acc_next;
                scount_reg  <= scount_next;
            end
        end
        if (accept) begin
            mode_reg <= s_tuser;
            data_reg <= s_tdata[7:0];
            bit_reg  <= s_tdata[8];
        end
        if (load_out) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_rem_while_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REM |-> rem_stat.busy)
        else $error("waiting on remainder unit that is not busy");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the finishing state");

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tuser_reg[0] && m_tuser_reg[1]))
        else $error("result flags both a ROM access and a save write");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("result register overwritten while held");
`endif

endmodule

// File: dv/cart_address_sequencer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for cart_address_sequencer_core: directed and random accesses,
// each result checked against an in-bench prediction. Depends on cas_pkg and the RTL.
module cart_address_sequencer_core_tb;
    import cas_pkg::*;

    localparam int                STALL_LIMIT    = 2000;
    localparam int                SETTLE_CYCLES  = 40;
    localparam int                IDLE_PCT       = 33;
    localparam int                RANDOM_PHASES  = 5;
    localparam int unsigned       PHASE_ACCESSES = 120;
    localparam logic [SIZE_W-1:0] SIZE_MAX       = 21'h100000;
    localparam logic [SIZE_W-1:0] ACCESS_SPAN    = 21'h020000;
    localparam logic [SIZE_W-1:0] SHIFT_LEN_MAX  = 21'd32;
    localparam logic [SIZE_W-1:0] SHIFT_LEN_NONE = 21'd0;
    localparam logic [3:0]        MODE_UNUSED_FIRST = 4'd9;
    localparam logic [3:0]        MODE_UNUSED_LAST  = 4'd15;

    typedef struct packed {
        logic                  rom_valid;
        logic [OUT_ADDR_W-1:0] rom_address;
        logic                  rom_in_range;
        logic                  save_write;
        logic [OUT_ADDR_W-1:0] save_address;
        logic [BYTE_W-1:0]     save_data;
    } access_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BANK0_SIZE;
    logic [SIZE_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;  // [7:0] data_byte, [8] serial_bit
    logic [3:0]             s_tuser   = MODE_READ;  // [3:0] mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [55:0]            m_tdata;  // [19:0] rom_address, [20] rom_in_range,
                                      // [40:21] save_address, [48:41] save_data
    logic [1:0]             m_tuser;  // [0] rom_valid, [1] save_write

    // Predicted block state and register copies
    logic [COUNTER_W-1:0]   addr_count   = '0;
    logic                   bank_one     = 1'b0;
    logic [COUNTER_W-1:0]   serial_shreg = '0;
    logic [SHIFT_LEN_W-1:0] serial_bits  = '0;
    logic [SIZE_W-1:0]      bank0_len    = '0;
    logic [SIZE_W-1:0]      bank1_base   = '0;
    logic [SIZE_W-1:0]      bank1_len    = '0;
    logic [SIZE_W-1:0]      rom_len      = '0;
    logic [SHIFT_LEN_W-1:0] shift_len    = SHIFT_LEN_RESET;
    logic [SIZE_W-1:0]      save_len     = '0;

    access_result_t expected_results[$];
    bit             traffic_idle   = 1'b1;
    int             error_count    = 0;
    int unsigned    accesses_sent  = 0;
    int unsigned    results_checked = 0;
    int unsigned    settings_used  = 0;
    int             stall_cycles   = 0;

    cart_address_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= !traffic_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compute the result of one access and advance the predicted state
    function automatic access_result_t predict_access(logic [3:0] mode, logic [7:0] data,
                                                      logic sbit);
        access_result_t       res;
        logic [COUNTER_W-1:0] base;
        logic [COUNTER_W-1:0] span;
        logic [COUNTER_W-1:0] rom_addr;
        res = '0;
        case (mode)
            MODE_READ, MODE_PEEK: begin
                base = bank_one ? COUNTER_W'(bank1_base) : '0;
                span = bank_one ? COUNTER_W'(bank1_len) : COUNTER_W'(bank0_len);
                rom_addr = base + ((span != 0) ? addr_count % span : addr_count);
                res.rom_valid    = 1'b1;
                res.rom_address  = OUT_ADDR_W'(rom_addr & ROM_ADDR_MASK);
                res.rom_in_range = rom_addr < COUNTER_W'(rom_len);
                if (mode == MODE_READ) addr_count = addr_count + COUNTER_W'(1);
            end
            MODE_WRITE: begin
                if (save_len != 0 && addr_count < COUNTER_W'(save_len)) begin
                    res.save_write   = 1'b1;
                    res.save_address = addr_count[OUT_ADDR_W-1:0];
                    res.save_data    = data;
                end
                addr_count = addr_count + COUNTER_W'(1);
            end
            MODE_SET_LOW:  addr_count = {16'b0, addr_count[15:8], data};
            MODE_SET_HIGH: addr_count = {16'b0, data, addr_count[7:0]};
            MODE_SHIFT_BIT: begin
                serial_bits  = serial_bits + SHIFT_LEN_W'(1);
                serial_shreg = {serial_shreg[COUNTER_W-2:0], sbit};
                if (serial_bits >= shift_len) begin
                    addr_count   = serial_shreg;
                    serial_bits  = '0;
                    serial_shreg = '0;
                end
            end
            MODE_BANK0_PG, MODE_BANK1_PG: begin
                bank_one   = (mode == MODE_BANK1_PG);
                addr_count = {16'b0, data, addr_count[7:0]};
            end
            MODE_SEL_BANK: bank_one = (data != 0);
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_access(logic [3:0] mode, logic [7:0] data, logic sbit);
        if (traffic_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, sbit, data};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_access(mode, data, sbit));
        if (mode <= MODE_SEL_BANK) accesses_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no drop in between
    task automatic write_reg(cfg_index_t idx, logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BANK0_SIZE:   bank0_len  = value;
            CFG_BANK1_OFFSET: bank1_base = value;
            CFG_BANK1_SIZE:   bank1_len  = value;
            CFG_ROM_SIZE:     rom_len    = value;
            CFG_SHIFT_LENGTH: shift_len  = value[SHIFT_LEN_W-1:0];
            CFG_SAVE_RAM:     save_len   = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [SIZE_W-1:0] b0_size, logic [SIZE_W-1:0] b1_offset,
                                  logic [SIZE_W-1:0] b1_size, logic [SIZE_W-1:0] rom_bytes,
                                  logic [SIZE_W-1:0] shift_bits,
                                  logic [SIZE_W-1:0] save_bytes);
        drain_results();
        write_reg(CFG_BANK0_SIZE, b0_size);
        write_reg(CFG_BANK1_OFFSET, b1_offset);
        write_reg(CFG_BANK1_SIZE, b1_size);
        write_reg(CFG_ROM_SIZE, rom_bytes);
        write_reg(CFG_SHIFT_LENGTH, shift_bits);
        write_reg(CFG_SAVE_RAM, save_bytes);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_burst();
        int         reps;
        logic [3:0] mode;
        reps = $urandom_range(1, 6);
        repeat (reps) begin
            mode = 4'($urandom_range(MODE_READ, MODE_WRITE));
            send_access(mode, 8'($urandom), 1'($urandom));
        end
    endtask

    // Mostly well-formed address loads followed by bursts, plus some noise
    task automatic run_random_traffic(int unsigned count);
        int unsigned          stop_at;
        int                   reps;
        logic [COUNTER_W-1:0] value;
        logic [3:0]           mode;
        stop_at = accesses_sent + count;
        while (accesses_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    case ($urandom_range(0, 2))
                        0:       mode = MODE_SET_HIGH;
                        1:       mode = MODE_BANK0_PG;
                        default: mode = MODE_BANK1_PG;
                    endcase
                    send_access(mode, 8'($urandom), 1'($urandom));
                    send_access(MODE_SET_LOW, 8'($urandom), 1'($urandom));
                    send_burst();
                end
                4, 5, 6: begin
                    case ($urandom_range(0, 3))
                        0:       value = '1;
                        1:       value = {12'hfff, 20'($urandom)};
                        default: value = $urandom;
                    endcase
                    reps = (shift_len == 0) ? 1 : int'(shift_len);
                    // cut the odd load short to knock the bit count out of step
                    if ($urandom_range(0, 9) == 0) reps = $urandom_range(1, reps);
                    for (int i = reps - 1; i >= 0; i--) begin
                        send_access(MODE_SHIFT_BIT, 8'($urandom), value[i]);
                    end
                    send_burst();
                end
                7: send_access(MODE_SEL_BANK, $urandom_range(0, 1) ? 8'h00 : 8'($urandom),
                               1'($urandom));
                default: begin
                    mode = 4'($urandom_range(MODE_READ, MODE_UNUSED_LAST));
                    send_access(mode, 8'($urandom), 1'($urandom));
                end
            endcase
        end
    endtask

    task automatic test_reset_state();
        send_access(MODE_READ, 8'h00, 1'b0);
        send_access(MODE_PEEK, 8'hff, 1'b1);
        send_access(MODE_WRITE, 8'hff, 1'b0);
        send_access(MODE_UNUSED_LAST, 8'hff, 1'b1);
        send_access(MODE_UNUSED_FIRST, 8'h00, 1'b0);
    endtask

    task automatic test_counter_and_banks();
        apply_settings(SIZE_MAX, SIZE_MAX, 21'd1, SIZE_MAX, SHIFT_LEN_MAX, SIZE_MAX);
        send_access(MODE_SET_HIGH, 8'hff, 1'b0);
        send_access(MODE_SET_LOW, 8'h00, 1'b0);
        send_access(MODE_SET_LOW, 8'hff, 1'b1);
        send_access(MODE_WRITE, 8'ha5, 1'b0);
        send_access(MODE_READ, 8'h00, 1'b0);
        send_access(MODE_BANK1_PG, 8'h80, 1'b0);
        send_access(MODE_PEEK, 8'h00, 1'b0);
        send_access(MODE_SEL_BANK, 8'h00, 1'b0);
        send_access(MODE_PEEK, 8'h00, 1'b0);
        send_access(MODE_SEL_BANK, 8'hff, 1'b0);
        send_access(MODE_READ, 8'h00, 1'b0);
        send_access(MODE_BANK0_PG, 8'h00, 1'b1);
        send_access(MODE_READ, 8'hff, 1'b0);
    endtask

    // Zero shift length loads the counter on every bit
    task automatic test_short_shift();
        apply_settings(SIZE_MAX, 21'h0fffff, 21'd0, 21'd1, SHIFT_LEN_NONE, 21'd1);
        send_access(MODE_SHIFT_BIT, 8'h00, 1'b1);
        send_access(MODE_READ, 8'h00, 1'b0);
        send_access(MODE_SHIFT_BIT, 8'hff, 1'b0);
        send_access(MODE_PEEK, 8'h00, 1'b0);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_settings(SIZE_W'($urandom_range(1, ACCESS_SPAN)),
                                  SIZE_W'($urandom_range(0, SIZE_MAX)),
                                  SIZE_W'($urandom_range(0, ACCESS_SPAN)),
                                  SIZE_W'($urandom_range(0, SIZE_MAX)),
                                  21'd8, SIZE_W'($urandom_range(0, ACCESS_SPAN)));
                1: apply_settings(SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX, SHIFT_LEN_MAX,
                                  SIZE_MAX);
                // no wrap, bank one high in the map: offset plus counter wraps past 2^32
                2: apply_settings(21'd0, SIZE_MAX, 21'd0, SIZE_MAX, SHIFT_LEN_MAX, SIZE_MAX);
                3: apply_settings(SIZE_W'($urandom_range(0, SIZE_MAX)),
                                  SIZE_W'($urandom_range(0, SIZE_MAX)),
                                  SIZE_W'($urandom_range(0, SIZE_MAX)),
                                  SIZE_W'($urandom_range(0, SIZE_MAX)),
                                  SIZE_W'($urandom_range(0, SHIFT_LEN_MAX)),
                                  SIZE_W'($urandom_range(0, ACCESS_SPAN)));
                default: apply_settings(21'd1, 21'd1, 21'd1, 21'd1, 21'd16, 21'd1);
            endcase
            traffic_idle = (p != 2);
            run_random_traffic(PHASE_ACCESSES);
        end
        traffic_idle = 1'b1;
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
                     want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        access_result_t got;
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rom_valid    = m_tuser[0];
            got.save_write   = m_tuser[1];
            got.rom_address  = m_tdata[19:0];
            got.rom_in_range = m_tdata[20];
            got.save_address = m_tdata[40:21];
            got.save_data    = m_tdata[48:41];
            if (expected_results.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, actual tuser 0x%0h tdata 0x%0h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("rom_valid", 32'(want.rom_valid), 32'(got.rom_valid));
                check_field("rom_address", 32'(want.rom_address), 32'(got.rom_address));
                check_field("rom_in_range", 32'(want.rom_in_range), 32'(got.rom_in_range));
                check_field("save_write", 32'(want.save_write), 32'(got.save_write));
                check_field("save_address", 32'(want.save_address), 32'(got.save_address));
                check_field("save_data", 32'(want.save_data), 32'(got.save_data));
                results_checked++;
            end
        end
    end

    // Watchdog: count cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles, %0d results outstanding", $time,
                     stall_cycles, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_counter_and_banks();
        test_short_shift();
        test_random_phases();
        drain_results();
        $display("Checked %0d results from %0d accesses over %0d register settings,",
                 results_checked, accesses_sent, settings_used + 1);
        $display("covering byte and page loads, serial loads, bank wrap and save RAM writes.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
